>>> src/prg_pkg.sv
`default_nettype none

package prg_pkg;

  localparam int MAX_STEPS_DEF = 64;

  localparam int LEN_W     = 7;
  localparam int PAT_W     = 64;
  localparam int PAT_IDX_W = 6;
  localparam int ROT_W     = 8;
  localparam int NUM_W     = 16;
  localparam int DIV_W     = 16;
  localparam int DVS_W     = 8;

  localparam logic [PAT_W-1:0] RESET_PATTERN = 64'h49;
  localparam logic [LEN_W-1:0] RESET_LENGTH  = 7'd8;
  localparam logic [LEN_W-1:0] RESET_ONSETS  = 7'd3;

  typedef struct packed {
    logic [LEN_W-1:0]        vertex_count;
    logic [LEN_W-1:0]        step_count;
    logic signed [ROT_W-1:0] rotation;
  } prg_req_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern_bits;
    logic [LEN_W-1:0] pattern_length;
    logic [LEN_W-1:0] onsets_found;
    logic             accepted;
  } prg_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> src/polygon_rhythm_generator.sv
`default_nettype none

// Channel  Dir  Payload    Handshake
// req      in   prg_req_t  req_valid / req_stall   (vertex, step count, rotation)
// rsp      out  prg_rsp_t  rsp_valid / rsp_stall   (pattern, length, onsets, accepted)
//
// A rejected request (zero vertices or zero steps) goes straight to ST_OUT.
// A built pattern needs one pass through the shared 16-step restoring divider
// per vertex, each begun from a start state (ST_ROT or ST_START).
// req_stall is high from the transfer until the result is loaded into rsp; a
// result still waiting on rsp_stall does not block the next request.
// rst (synchronous) restores the held pattern to steps 0, 3 and 6 of 8.

module polygon_rhythm_generator
  import prg_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire prg_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output prg_rsp_t      rsp
);

  localparam int POS_W = $clog2(MAX_STEPS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROT   = 3'd1;
  localparam logic [2:0] ST_ROTW  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state;

  // request as captured
  logic [LEN_W-1:0]        vc;
  logic [LEN_W-1:0]        sc;
  logic signed [ROT_W-1:0] rot;
  logic                    acc;

  // running numerator i*steps + rotation*vertices, previous rounded position
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] q_prev;
  logic [POS_W-1:0]        pos;
  logic [LEN_W-1:0]        vidx;

  logic [PAT_W-1:0] build;
  logic [LEN_W-1:0] build_cnt;

  logic [PAT_W-1:0] held_pattern;
  logic [LEN_W-1:0] held_length;
  logic [LEN_W-1:0] held_count;

  div_req_t dreq;
  div_rsp_t drsp;

  logic                    req_xfer;
  logic                    rsp_free;
  logic [LEN_W-1:0]        sc_in;
  logic                    num_neg;
  logic [NUM_W-1:0]        num_mag;
  logic [DIV_W-1:0]        num_dvd;
  logic [DVS_W-1:0]        rot_mag;
  logic signed [NUM_W-1:0] quot_s;
  logic [NUM_W-1:0]        step_d;
  logic [POS_W:0]          pos_sum;
  logic [POS_W:0]          pos_wrap;
  logic [POS_W-1:0]        pos_first;
  logic [POS_W-1:0]        new_pos;
  logic [PAT_IDX_W-1:0]    idx;
  logic [PAT_W-1:0]        onehot;
  logic [LEN_W-1:0]        vidx_inc;

  assign req_xfer  = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // clamp step count to the supported length
  assign sc_in = (req.step_count > LEN_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS) : req.step_count;

  // round-half-away division of the numerator: (2|num| + v) / (2v), sign restored
  assign num_neg = num[NUM_W-1];
  assign num_mag = num_neg ? NUM_W'(-num) : NUM_W'(num);
  assign num_dvd = {num_mag[NUM_W-2:0], 1'b0} + DIV_W'(vc);
  assign rot_mag = rot[ROT_W-1] ? DVS_W'(-rot) : DVS_W'(rot);

  always_comb begin
    dreq.start    = (state == ST_ROT) || (state == ST_START);
    dreq.dividend = (state == ST_ROT) ? DIV_W'(rot_mag) : num_dvd;
    dreq.divisor  = (state == ST_ROT) ? DVS_W'(sc) : {vc, 1'b0};
  end

  prg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  // Rounded positions never decrease and grow by at most about steps/vertices,
  // so advance the previous position and wrap with a single subtract.
  assign quot_s   = num_neg ? -$signed(drsp.quotient) : $signed(drsp.quotient);
  assign step_d   = NUM_W'(quot_s - q_prev);
  assign pos_sum  = {1'b0, pos} + step_d[POS_W:0];
  assign pos_wrap = (pos_sum >= sc[POS_W:0]) ? pos_sum - sc[POS_W:0] : pos_sum;

  // vertex 0 sits at rotation mod steps, made non-negative
  assign pos_first = (rot[ROT_W-1] && drsp.remainder != '0)
                   ? POS_W'(DVS_W'(sc) - drsp.remainder)
                   : POS_W'(drsp.remainder);

  assign new_pos  = (state == ST_ROTW) ? pos_first : pos_wrap[POS_W-1:0];
  assign idx      = PAT_IDX_W'(new_pos);
  assign onehot   = PAT_W'(1) << idx;
  assign vidx_inc = vidx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rsp_valid    <= 1'b0;
      held_pattern <= RESET_PATTERN;
      held_length  <= RESET_LENGTH;
      held_count   <= RESET_ONSETS;
    end else begin
      // drop a delivered result; ST_OUT sets rsp_valid on its own
      if (rsp_valid && !rsp_stall && state != ST_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            if (req.vertex_count == '0 || sc_in == '0) begin
              state <= ST_OUT;
            end else begin
              state <= ST_ROT;
            end
          end
        end
        ST_ROT: begin
          state <= ST_ROTW;
        end
        ST_ROTW: begin
          if (drsp.done) begin
            state <= (vc == LEN_W'(1)) ? ST_OUT : ST_START;
          end
        end
        ST_START: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (drsp.done) begin
            state <= (vidx_inc == vc) ? ST_OUT : ST_START;
          end
        end
        ST_OUT: begin
          // hold until the output register frees up, then commit
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
            if (acc) begin
              held_pattern <= build;
              held_length  <= sc;
              held_count   <= build_cnt;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      vc  <= req.vertex_count;
      sc  <= sc_in;
      rot <= req.rotation;
      acc <= (req.vertex_count != '0) && (sc_in != '0);
      num <= NUM_W'($signed(req.rotation) * $signed({1'b0, req.vertex_count}));
    end
    if (state == ST_ROTW && drsp.done) begin
      build     <= onehot;
      build_cnt <= LEN_W'(1);
      pos       <= new_pos;
      q_prev    <= NUM_W'(rot);
      vidx      <= LEN_W'(1);
      num       <= NUM_W'(num + $signed({{(NUM_W - LEN_W){1'b0}}, sc}));
    end
    if (state == ST_WAIT && drsp.done) begin
      // colliding vertices share one onset
      build     <= build | onehot;
      build_cnt <= build[idx] ? build_cnt : build_cnt + 1'b1;
      pos       <= new_pos;
      q_prev    <= quot_s;
      vidx      <= vidx_inc;
      num       <= NUM_W'(num + $signed({{(NUM_W - LEN_W){1'b0}}, sc}));
    end
    if (state == ST_OUT && rsp_free) begin
      rsp.accepted       <= acc;
      rsp.pattern_bits   <= acc ? build : held_pattern;
      rsp.pattern_length <= acc ? sc : held_length;
      rsp.onsets_found   <= acc ? build_cnt : held_count;
    end
  end

  a_count_fits: assert property (@(posedge clk) disable iff (rst)
    held_count <= held_length) else $error("onset count exceeds length");

  a_high_clear: assert property (@(posedge clk) disable iff (rst)
    (held_pattern >> held_length) == '0) else $error("onset beyond pattern length");

  a_xfer_busy: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state != ST_IDLE) else $error("request transfer left block idle");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == ST_ROTW || state == ST_WAIT))
    else $error("divider result with no consumer");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> LEN_W'(pos) < sc) else $error("position outside pattern");

endmodule

`default_nettype wire

>>> src/prg_div.sv
`default_nettype none

module prg_div
  import prg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t dreq,
  output div_rsp_t      drsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0] shifted;
  logic           fits;

  // one restoring step: bring down the next dividend bit, try the subtract
  assign shifted = {rem, dvd[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dreq.start) begin
      dvd <= dreq.dividend;
      dvs <= dreq.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], fits};
      rem <= fits ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
    end
  end

  assign drsp.done      = done;
  assign drsp.quotient  = dvd;
  assign drsp.remainder = rem;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !busy) else $error("divider started while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    dreq.start |=> busy) else $error("divider did not go busy");

  a_rem_small: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dvs) else $error("remainder not below divisor");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while still busy");

endmodule

`default_nettype wire

>>> tb/tb_polygon_rhythm_generator.sv
`timescale 1ns / 100ps

module tb_polygon_rhythm_generator;
  import prg_pkg::*;

  // Budget for the whole run, in clock cycles. The slowest legal run (every
  // request at 127 vertices, plus stalls) stays well under this.
  localparam int CYCLE_LIMIT = 6_000_000;
  // Cycles to keep watching rsp after the last expected result has arrived.
  localparam int TAIL_CYCLES = 64;
  // Length of the forced receiver hold-off that backs up the block.
  localparam int HOLD_CYCLES = 600;
  // Percent chance that a side idles in a given cycle.
  localparam int IDLE_PCT = 29;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  prg_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  prg_rsp_t rsp;

  polygon_rhythm_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Requests waiting for the driver, and the responses owed by the block.
  prg_req_t request_backlog[$];
  prg_rsp_t pattern_due[$];

  // Our own copy of the pattern the block holds.
  logic [PAT_W-1:0] held_bits = 64'h49;
  logic [LEN_W-1:0] held_steps = 7'd8;

  // Shared knobs: calm turns off idling on both sides; bumping hold_request
  // asks the receiver for one long hold-off.
  bit calm = 1'b0;
  int hold_request = 0;
  int hold_served = 0;
  int hold_left = 0;

  int requests_queued = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int patterns_built = 0;
  int patterns_rejected = 0;
  int widest_vertices = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Place every vertex on its nearest step and, for an accepted request, make
  // the result the held pattern; return the response the block owes for it.
  function automatic prg_rsp_t place_vertices(prg_req_t r);
    int v;
    int s;
    int rot;
    int num;
    int mag;
    int q;
    int pos;
    logic [PAT_W-1:0] bits;
    logic [PAT_W-1:0] mask;
    prg_rsp_t o;
    v = int'(r.vertex_count);
    s = int'(r.step_count);
    rot = int'($signed(r.rotation));
    o = '0;
    if (s > MAX_STEPS_DEF) s = MAX_STEPS_DEF;
    if (v != 0 && s != 0) begin
      bits = '0;
      for (int i = 0; i < v; i++) begin
        // round((i*s + rot*v) / v), halves away from zero, then wrap
        num = i * s + rot * v;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + v) / (2 * v);
        if (num < 0) q = -q;
        pos = q % s;
        if (pos < 0) pos += s;
        bits[pos] = 1'b1;
      end
      held_bits = bits;
      held_steps = LEN_W'(s);
      o.accepted = 1'b1;
    end
    mask = (held_steps >= PAT_W) ? '1 : ((PAT_W'(1) << held_steps) - 1);
    o.pattern_bits = held_bits & mask;
    o.pattern_length = held_steps;
    o.onsets_found = LEN_W'($countones(o.pattern_bits));
    return o;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
  endtask

  task automatic queue_request(input int v, input int s, input int rot);
    prg_req_t r;
    r.vertex_count = LEN_W'(v);
    r.step_count = LEN_W'(s);
    r.rotation = ROT_W'(rot);
    request_backlog = {request_backlog, r};
    requests_queued++;
  endtask

  // Mostly well-formed requests with small sizes; a few large vertex counts,
  // saturating step counts, wild rotations and rejected requests as noise.
  task automatic queue_random(input int n);
    int pick;
    int v;
    int s;
    int rot;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) rot = $urandom_range(0, 255);
      else rot = int'($urandom_range(0, 128)) - 64;
      if (pick < 8) begin
        // rejected: zero vertices or zero steps, rest anything
        v = $urandom_range(0, 127);
        s = $urandom_range(0, 127);
        if ($urandom_range(0, 1) == 0) v = 0;
        else s = 0;
      end else if (pick < 12) begin
        v = $urandom_range(64, 127);
        s = $urandom_range(1, 127);
      end else begin
        v = $urandom_range(1, 24);
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
      end
      queue_request(v, s, rot);
    end
  endtask

  // Driver: account for a transfer, then offer the next request or idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        pattern_due = {pattern_due, place_vertices(req)};
        if (int'(req.vertex_count) > widest_vertices)
          widest_vertices = int'(req.vertex_count);
        requests_taken++;
      end
      // a stalled request holds its payload and stays valid
      if (!req_valid || !req_stall) begin
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
          req_valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          req_valid <= 1'b1;
          req <= request_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response transfer, then decide the next stall.
  always @(posedge clk) begin
    prg_rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (pattern_due.size() == 0) begin
          flag_mismatch("response with nothing outstanding", rsp.pattern_bits, '0);
        end else begin
          want = pattern_due.pop_front();
          if (rsp.pattern_bits !== want.pattern_bits)
            flag_mismatch("pattern_bits", rsp.pattern_bits, want.pattern_bits);
          if (rsp.pattern_length !== want.pattern_length)
            flag_mismatch("pattern_length", 64'(rsp.pattern_length), 64'(want.pattern_length));
          if (rsp.onsets_found !== want.onsets_found)
            flag_mismatch("onsets_found", 64'(rsp.onsets_found), 64'(want.onsets_found));
          if (rsp.accepted !== want.accepted)
            flag_mismatch("accepted", 64'(rsp.accepted), 64'(want.accepted));
          if (want.accepted) patterns_built++;
          else patterns_rejected++;
        end
      end
      // start a long hold-off when asked, and count it down here
      if (hold_served != hold_request) begin
        hold_served = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               pattern_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: rejections against the reset pattern, extremes of every field,
    // saturation, collisions, halves on both sides of zero, wrap-around.
    queue_request(0, 8, 0);
    queue_request(4, 0, 0);
    queue_request(0, 0, 0);
    queue_request(1, 1, 0);
    queue_request(3, 8, 0);
    queue_request(64, 64, 0);
    queue_request(127, 127, -128);
    queue_request(0, 127, -1);
    queue_request(5, 64, 127);
    queue_request(7, 12, -64);
    queue_request(7, 12, 64);
    queue_request(3, 7, -1);
    queue_request(65, 64, 3);
    queue_request(2, 100, 5);
    queue_request(10, 3, 0);
    queue_request(4, 16, -128);
    queue_request(4, 6, 0);
    queue_request(4, 6, -1);
    queue_request(2, 3, -2);
    queue_request(127, 1, 0);
    queue_request(1, 64, -65);
    queue_request(127, 0, 127);

    // Pressure: hold the receiver off while a burst of short requests piles up.
    while (request_backlog.size() != 0) @(posedge clk);
    hold_request = hold_request + 1;
    for (int k = 0; k < 16; k++)
      queue_request($urandom_range(1, 6), $urandom_range(1, 64),
                    int'($urandom_range(0, 128)) - 64);

    // Random, in three stretches; the middle one runs with no idling.
    queue_random(190);
    while (request_backlog.size() != 0) @(posedge clk);
    calm = 1'b1;
    queue_random(160);
    while (request_backlog.size() != 0) @(posedge clk);
    calm = 1'b0;
    queue_random(190);

    // Drain: every request transferred and every response back, then linger.
    while (requests_taken != requests_queued || pattern_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pattern_due.size() != 0)
      flag_mismatch("responses never delivered", '0, 64'(pattern_due.size()));

    $display("Covered %0d requests: %0d patterns built, %0d rejected, up to %0d vertices.",
             requests_taken, patterns_built, patterns_rejected, widest_vertices);
    $display("Included a %0d-cycle receiver hold-off and an idle-free stretch; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
